@@ hw/rtl/ssort_pkg.sv @@
// ----------------------------------------------------------------------------
// ssort_pkg
// Shared types and constants for the selection sort engine.
// ----------------------------------------------------------------------------
`default_nettype none

package ssort_pkg;

	localparam int DATA_W = 32;

	typedef logic signed [DATA_W-1:0] data_t;

	// Control from the sequencer to the compare unit
	typedef struct packed {
		logic start;       // begin a new pass, forget the current minimum
		logic cand_vld;    // a candidate element is on the read port this cycle
		logic cand_taken;  // the candidate was already emitted in an earlier pass
	} scan_ctl_t;

endpackage

`default_nettype wire

@@ hw/rtl/selection_sort_engine.sv @@
// ----------------------------------------------------------------------------
// selection_sort_engine
// Input items are taken one per cycle while a set is collected.
// Each result of an N-element set takes a fresh pass with out_ready high
// (N memory reads, the registered read data, a hand-over, then the emit),
// so a set drains in N such passes; in_ready stays low until it is done.
// Reset: state, fill count, taken marks and overflow flag clear at once;
// the element memory is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module selection_sort_engine #(
	parameter int MAX_ELEMENTS = 64
) (
	input  wire               clk,
	input  wire               arst_n,
	// input item channel
	input  wire               in_valid,
	output logic              in_ready,
	input  ssort_pkg::data_t  value,
	input  wire               last_in,
	// result item channel
	output logic              out_valid,
	input  wire               out_ready,
	output ssort_pkg::data_t  sorted_value,
	output logic              last_out,
	output logic              overflow
);
	import ssort_pkg::*;

	localparam int IDX_W = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
	localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
	localparam logic [CNT_W-1:0] FULL = CNT_W'(MAX_ELEMENTS);

	// Sequencer states: collect items, scan for the minimum, present a result
	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_EMIT = 3'b100
	} state_t;

	state_t            state_q;
	state_t            state_d;
	logic [CNT_W-1:0]  fill_q;
	logic [CNT_W-1:0]  emit_cnt_q;
	logic [CNT_W-1:0]  scan_idx_q;
	logic              dropped_q;
	logic              last_q;
	logic [MAX_ELEMENTS-1:0] taken_q;

	// read pipeline: the candidate index rides along with the memory read
	logic              cand_vld_s1;
	logic [IDX_W-1:0]  cand_idx_s1;

	logic              in_acc;
	logic              out_acc;
	logic              wr_en;
	logic              rd_en;
	logic              scan_done;
	logic              pass_start;
	data_t             rd_data;
	logic [IDX_W-1:0]  best_idx;
	data_t             best_val;
	scan_ctl_t         scan_ctl;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_EMIT);

	// store the item while there is room; past the depth it is dropped
	assign wr_en = in_acc && (fill_q != FULL);

	// issue one read per cycle until every stored element was presented
	assign rd_en     = (state_q == ST_SCAN) && (scan_idx_q != fill_q);
	assign scan_done = (state_q == ST_SCAN) && (scan_idx_q == fill_q) && !cand_vld_s1;

	// a new pass starts when a set closes or when a non-final result leaves
	assign pass_start = (in_acc && last_in) || (out_acc && !last_q);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc && last_in) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan_done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (out_acc) begin
					state_d = last_q ? ST_IDLE : ST_SCAN;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fill_q      <= '0;
			emit_cnt_q  <= '0;
			scan_idx_q  <= '0;
			dropped_q   <= 1'b0;
			last_q      <= 1'b0;
			taken_q     <= '0;
			cand_vld_s1 <= 1'b0;
		end else begin
			state_q     <= state_d;
			cand_vld_s1 <= rd_en;

			// collect: advance the fill count or note the drop
			if (in_acc) begin
				if (wr_en) begin
					fill_q <= fill_q + CNT_W'(1);
				end else begin
					dropped_q <= 1'b1;
				end
			end

			// restart the read sweep at the head of each pass
			if (pass_start) begin
				scan_idx_q <= '0;
			end else if (rd_en) begin
				scan_idx_q <= scan_idx_q + CNT_W'(1);
			end

			// flag the result that empties the set
			if (scan_done) begin
				last_q <= ((emit_cnt_q + CNT_W'(1)) == fill_q);
			end

			// a result leaves: mark it taken, or drop the whole set when final
			if (out_acc) begin
				if (last_q) begin
					taken_q    <= '0;
					fill_q     <= '0;
					emit_cnt_q <= '0;
					dropped_q  <= 1'b0;
				end else begin
					taken_q[best_idx] <= 1'b1;
					emit_cnt_q        <= emit_cnt_q + CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			cand_idx_s1 <= scan_idx_q[IDX_W-1:0];
		end
	end

	ssort_store #(
		.DEPTH (MAX_ELEMENTS),
		.IDX_W (IDX_W)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (fill_q[IDX_W-1:0]),
		.wr_data (value),
		.rd_en   (rd_en),
		.rd_addr (scan_idx_q[IDX_W-1:0]),
		.rd_data (rd_data)
	);

	assign scan_ctl.start      = pass_start;
	assign scan_ctl.cand_vld   = cand_vld_s1;
	assign scan_ctl.cand_taken = taken_q[cand_idx_s1];

	ssort_scan #(
		.IDX_W (IDX_W)
	) u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (scan_ctl),
		.cand_idx (cand_idx_s1),
		.cand_val (rd_data),
		.best_idx (best_idx),
		.best_val (best_val)
	);

	// the minimum register holds steady while a result is presented
	assign sorted_value = best_val;
	assign last_out     = last_q;
	assign overflow     = dropped_q;

endmodule

`default_nettype wire

@@ hw/rtl/ssort_store.sv @@
// ----------------------------------------------------------------------------
// ssort_store
// Element memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ssort_store #(
	parameter int DEPTH = 64,
	parameter int IDX_W = 6
) (
	input  wire                   clk,
	input  wire                   wr_en,
	input  wire [IDX_W-1:0]       wr_addr,
	input  ssort_pkg::data_t      wr_data,
	input  wire                   rd_en,
	input  wire [IDX_W-1:0]       rd_addr,
	output ssort_pkg::data_t      rd_data
);
	import ssort_pkg::*;

	data_t mem_q [DEPTH];
	data_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

@@ hw/rtl/ssort_scan.sv @@
// ----------------------------------------------------------------------------
// ssort_scan
// Shared signed compare unit: tracks the smallest untaken element of a pass.
// ----------------------------------------------------------------------------
`default_nettype none

module ssort_scan #(
	parameter int IDX_W = 6
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  ssort_pkg::scan_ctl_t  ctl,
	input  wire [IDX_W-1:0]       cand_idx,
	input  ssort_pkg::data_t      cand_val,
	output logic [IDX_W-1:0]      best_idx,
	output ssort_pkg::data_t      best_val
);
	import ssort_pkg::*;

	logic             found_q;
	logic [IDX_W-1:0] best_idx_q;
	data_t            best_val_q;
	logic             take;

	// Strict less-than keeps the earlier position on ties
	assign take = ctl.cand_vld && !ctl.cand_taken && (!found_q || (cand_val < best_val_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (ctl.start) begin
			found_q <= 1'b0;
		end else if (take) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!ctl.start && take) begin
			best_idx_q <= cand_idx;
			best_val_q <= cand_val;
		end
	end

	assign best_idx = best_idx_q;
	assign best_val = best_val_q;

endmodule

`default_nettype wire

@@ hw/rtl/ssort_chk.sv @@
// ----------------------------------------------------------------------------
// ssort_chk
// Port-level checks for the selection sort engine, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ssort_chk (
	input wire               clk,
	input wire               arst_n,
	input wire               in_valid,
	input wire               in_ready,
	input wire               last_in,
	input wire               out_valid,
	input wire               out_ready,
	input ssort_pkg::data_t  sorted_value,
	input wire               last_out,
	input wire               overflow
);

	// collecting and emitting never overlap
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input taken while a result is presented");

	// closing a set stops intake
	a_close_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && last_in) |=> !in_ready)
		else $error("intake continued after the closing item");

	// a final result returns the block to intake
	a_final_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && last_out) |=> (in_ready && !out_valid))
		else $error("block not ready after the final result");

	// a non-final result is followed by a fresh scan
	a_rescan: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !last_out) |=> (!out_valid && !in_ready))
		else $error("no scan between two results");

	// a stalled result holds its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=>
			(out_valid && $stable(sorted_value) && $stable(last_out) && $stable(overflow)))
		else $error("stalled result changed");

endmodule

bind selection_sort_engine ssort_chk u_ssort_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.last_in      (last_in),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.sorted_value (sorted_value),
	.last_out     (last_out),
	.overflow     (overflow)
);

`default_nettype wire
